/* rtl/lrusd_pkg.sv */
`timescale 1ns / 1ps
// shared types and constants of the lru stack reuse distance unit
package lrusd_pkg;

    localparam int DEPTH_DEFAULT = 256;

    localparam int ADDR_W    = 48;
    localparam int TAG_W     = 16;
    localparam int REG_W     = 9;
    localparam int DIST_W    = 9;
    localparam int CFG_IDX_W = 1;

    localparam logic [DIST_W-1:0] DIST_MAX       = 9'd511;
    localparam logic [REG_W-1:0]  LIMIT_RESET    = 9'd0;
    localparam logic [REG_W-1:0]  BIN_THR_RESET  = 9'd32;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LIMIT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BIN_THRESHOLD = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ENC,
        ST_UPD
    } state_t;

    // per-cycle commands broadcast to every stack cell
    typedef struct packed {
        logic cmp_en;
        logic shift_en;
    } cell_ctrl_t;

endpackage

/* rtl/lrusd_cell.sv */
`timescale 1ns / 1ps
// one entry of the lru stack: stored address, valid bit, compare and shift
module lrusd_cell #(
    parameter int INDEX = 0,
    parameter int IDX_W = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  lrusd_pkg::cell_ctrl_t           ctrl,
    input  logic [lrusd_pkg::ADDR_W-1:0]    cmp_addr,
    input  logic [IDX_W-1:0]                last,
    input  logic [lrusd_pkg::ADDR_W-1:0]    prev_addr,
    input  logic                            prev_valid,
    output logic [lrusd_pkg::ADDR_W-1:0]    addr_q,
    output logic                            valid_q,
    output logic                            match
);

    logic [lrusd_pkg::ADDR_W-1:0] addr_reg;
    logic [lrusd_pkg::ADDR_W-1:0] addr_next;
    logic                         valid_reg;
    logic                         valid_next;
    logic                         match_reg;
    logic                         match_next;

    always_comb
    begin
        addr_next  = addr_reg;
        valid_next = valid_reg;
        match_next = match_reg;
        if (ctrl.cmp_en)
        begin
            match_next = valid_reg && (addr_reg == cmp_addr);
        end
        // entries at or above the moving point take their upper neighbor
        if (ctrl.shift_en && (IDX_W'(INDEX) <= last))
        begin
            addr_next  = prev_addr;
            valid_next = prev_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg <= addr_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            match_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            match_reg <= match_next;
        end
    end

    assign addr_q  = addr_reg;
    assign valid_q = valid_reg;
    assign match   = match_reg;

endmodule

/* rtl/lrusd_encoder.sv */
`timescale 1ns / 1ps
// match vector to hit flag and stack position
module lrusd_encoder #(
    parameter int DEPTH = 256,
    parameter int IDX_W = 8
) (
    input  logic [DEPTH-1:0] match_vec,
    output logic             any,
    output logic [IDX_W-1:0] pos
);

    // addresses in the stack are distinct, so at most one bit is set
    always_comb
    begin
        pos = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (match_vec[i])
            begin
                pos = pos | IDX_W'(i);
            end
        end
    end

    assign any = |match_vec;

endmodule

/* rtl/lru_stack_reuse_distance_unit.sv */
`timescale 1ns / 1ps
// top level of the lru stack reuse distance unit
//
// one item is a memory access: address and stream_tag, taken at a rising edge
// with start high and busy low. each item gives one result, shown for exactly
// one cycle with done high: tag_out (the stream tag), hit, and distance_bin
// (position from the top of the stack, 1 for an immediate repeat, binned to a
// power of two above bin_threshold, 0 on a miss). the receiver cannot stall.
// timing: at the accept edge every cell compares the address; in ST_ENC the
// match position is encoded and registered; in ST_UPD the stack shifts and
// the result is registered, with done rising alongside it. busy is high in
// ST_ENC and ST_UPD, so a new item is taken only back in ST_IDLE, after the
// encode step (an or tree over the whole window) and the shift are done.
// configuration: cfg_we, cfg_index, cfg_data write window_limit (0) and
// bin_threshold (1); write them only while the unit is idle.
// reset: the stack empties at once (valid bits cleared), window_limit goes to
// 0 (full depth) and bin_threshold to 32; no clearing pass is needed.
module lru_stack_reuse_distance_unit #(
    parameter int WINDOW_DEPTH = lrusd_pkg::DEPTH_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [lrusd_pkg::ADDR_W-1:0]        address,
    input  logic [lrusd_pkg::TAG_W-1:0]         stream_tag,
    output logic                                done,
    output logic [lrusd_pkg::TAG_W-1:0]         tag_out,
    output logic                                hit,
    output logic [lrusd_pkg::DIST_W-1:0]        distance_bin,
    input  logic                                cfg_we,
    input  logic [lrusd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lrusd_pkg::REG_W-1:0]         cfg_data
);

    localparam int IDX_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int OCC_W = $clog2(WINDOW_DEPTH + 1);
    // working width for distance binning: room for the rounded-up power of two
    localparam int WW    = (OCC_W + 1 > lrusd_pkg::REG_W) ? OCC_W + 1 : lrusd_pkg::REG_W;

    // control state
    lrusd_pkg::state_t     state_reg;
    lrusd_pkg::state_t     state_next;
    lrusd_pkg::cell_ctrl_t ctrl;
    logic                  busy_int;

    // configuration
    logic [lrusd_pkg::REG_W-1:0] limit_reg;
    logic [lrusd_pkg::REG_W-1:0] thr_reg;

    // item in flight
    logic [lrusd_pkg::ADDR_W-1:0] addr_reg;
    logic [lrusd_pkg::TAG_W-1:0]  tag_reg;
    logic [IDX_W-1:0]             pos_reg;
    logic                         hit_reg;
    logic [OCC_W-1:0]             occ_reg;
    logic [OCC_W-1:0]             occ_next;

    // result registers
    logic                         done_reg;
    logic [lrusd_pkg::TAG_W-1:0]  tag_out_reg;
    logic                         hit_out_reg;
    logic [lrusd_pkg::DIST_W-1:0] dist_reg;
    logic [lrusd_pkg::DIST_W-1:0] dist_next;

    // stack chain
    logic [lrusd_pkg::ADDR_W-1:0] cell_addr [WINDOW_DEPTH];
    logic [WINDOW_DEPTH-1:0]      valid_vec;
    logic [WINDOW_DEPTH-1:0]      match_vec;
    logic                         enc_any;
    logic [IDX_W-1:0]             enc_pos;

    logic [OCC_W-1:0]             cap;
    logic                         full;
    logic [IDX_W-1:0]             last;

    logic [WW-1:0]                dist_raw;
    logic [WW-1:0]                smear;
    logic [WW-1:0]                binned;

    // ---------------------------------------------------------------- control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lrusd_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        busy_int   = 1'b1;
        unique case (state_reg)
            lrusd_pkg::ST_IDLE:
            begin
                busy_int = 1'b0;
                if (start)
                begin
                    // cells compare the incoming address at the accept edge
                    ctrl.cmp_en = 1'b1;
                    state_next  = lrusd_pkg::ST_ENC;
                end
            end
            lrusd_pkg::ST_ENC:
            begin
                state_next = lrusd_pkg::ST_UPD;
            end
            lrusd_pkg::ST_UPD:
            begin
                ctrl.shift_en = 1'b1;
                state_next    = lrusd_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = lrusd_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy = busy_int;

    // ---------------------------------------------------------- configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= lrusd_pkg::LIMIT_RESET;
            thr_reg   <= lrusd_pkg::BIN_THR_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                lrusd_pkg::CFG_WINDOW_LIMIT:  limit_reg <= cfg_data;
                lrusd_pkg::CFG_BIN_THRESHOLD: thr_reg   <= cfg_data;
                default:                      ;
            endcase
        end
    end

    // -------------------------------------------------------------- item data
    always_ff @(posedge clk)
    begin
        if (ctrl.cmp_en)
        begin
            addr_reg <= address;
            tag_reg  <= stream_tag;
        end
        if (state_reg == lrusd_pkg::ST_ENC)
        begin
            pos_reg <= enc_pos;
            hit_reg <= enc_any;
        end
    end

    // ------------------------------------------------------------ stack cells
    // cell 0 is the most recent entry; on a shift each cell up to 'last'
    // takes its upper neighbor and cell 0 takes the new address
    for (genvar g = 0; g < WINDOW_DEPTH; g++)
    begin : g_cell
        logic [lrusd_pkg::ADDR_W-1:0] prev_addr;
        logic                         prev_valid;

        if (g == 0)
        begin : g_top
            assign prev_addr  = addr_reg;
            assign prev_valid = 1'b1;
        end
        else
        begin : g_rest
            assign prev_addr  = cell_addr[g-1];
            assign prev_valid = valid_vec[g-1];
        end

        lrusd_cell #(
            .INDEX (g),
            .IDX_W (IDX_W)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .cmp_addr   (address),
            .last       (last),
            .prev_addr  (prev_addr),
            .prev_valid (prev_valid),
            .addr_q     (cell_addr[g]),
            .valid_q    (valid_vec[g]),
            .match      (match_vec[g])
        );
    end

    lrusd_encoder #(
        .DEPTH (WINDOW_DEPTH),
        .IDX_W (IDX_W)
    ) u_encoder (
        .match_vec (match_vec),
        .any       (enc_any),
        .pos       (enc_pos)
    );

    // ---------------------------------------------------- window bookkeeping
    always_comb
    begin
        // a limit of zero or above the depth means the full depth
        if ((limit_reg == '0) || (WW'(limit_reg) > WW'(WINDOW_DEPTH)))
        begin
            cap = OCC_W'(WINDOW_DEPTH);
        end
        else
        begin
            cap = OCC_W'(limit_reg);
        end
        full = (occ_reg >= cap);

        occ_next = occ_reg;
        if (hit_reg)
        begin
            last = pos_reg;
        end
        else if (full)
        begin
            // evict the least recent entry, occupancy stays
            last = IDX_W'(occ_reg - OCC_W'(1));
        end
        else
        begin
            last     = IDX_W'(occ_reg);
            occ_next = occ_reg + OCC_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
        end
        else if (ctrl.shift_en)
        begin
            occ_reg <= occ_next;
        end
    end

    // ------------------------------------------------------ distance binning
    always_comb
    begin
        dist_raw = WW'(pos_reg) + WW'(1);
        // round up to a power of two: smear the msb of d-1 downward, add one
        smear = dist_raw - WW'(1);
        for (int k = 1; k < WW; k = k * 2)
        begin
            smear = smear | (smear >> k);
        end
        if ((thr_reg != '0) && (dist_raw > WW'(thr_reg)))
        begin
            binned = smear + WW'(1);
        end
        else
        begin
            binned = dist_raw;
        end

        if (!hit_reg)
        begin
            dist_next = '0;
        end
        else if (binned > WW'(lrusd_pkg::DIST_MAX))
        begin
            dist_next = lrusd_pkg::DIST_MAX;
        end
        else
        begin
            dist_next = binned[lrusd_pkg::DIST_W-1:0];
        end
    end

    // ---------------------------------------------------------------- result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ctrl.shift_en;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.shift_en)
        begin
            tag_out_reg <= tag_reg;
            hit_out_reg <= hit_reg;
            dist_reg    <= dist_next;
        end
    end

    assign done         = done_reg;
    assign tag_out      = tag_out_reg;
    assign hit          = hit_out_reg;
    assign distance_bin = dist_reg;

    // ------------------------------------------------------------ assertions
    // the number of valid entries always equals the occupancy
    a_valid_count: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_vec) == int'(occ_reg))
        else $error("valid bits disagree with occupancy");

    // distinct addresses: at most one cell can match
    a_one_match: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lrusd_pkg::ST_ENC) |-> $onehot0(match_vec))
        else $error("more than one stack entry matched");

    // a hit lies inside the occupied part of the stack
    a_hit_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == lrusd_pkg::ST_UPD) && hit_reg) |-> (OCC_W'(pos_reg) < occ_reg))
        else $error("hit position beyond occupancy");

    // a result follows only the stack update of an item
    a_done_after_update: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == lrusd_pkg::ST_UPD))
        else $error("result strobe without an update");

endmodule
